[rtl/vfqa_pkg.sv]
// ----------------------------------------------------------------------------
// vfqa_pkg
// shared types, codes and widths of the frame queue admission block
// ----------------------------------------------------------------------------
package vfqa_pkg;

   // default queue depth
   localparam int VFQA_QUEUE_DEPTH = 8;

   // field widths
   localparam int TAG_W    = 16;
   localparam int TIME_W   = 40;
   localparam int OTIME_W  = 54;
   localparam int MARK_W   = 4;
   localparam int STATUS_W = 3;
   localparam int FILL_W   = 4;
   localparam int CSR_IX_W = 2;
   localparam int CSR_D_W  = 4;
   localparam int SCALE_W  = 14;

   // ms to 100 ns units
   localparam logic [SCALE_W-1:0] MS_TO_100NS = 14'd10000;

   // register reset values
   localparam logic [MARK_W-1:0] HIGH_MARK_RST = 4'd6;
   localparam logic [MARK_W-1:0] LOW_MARK_RST  = 4'd2;

   // request modes
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // register indexes
   localparam logic [CSR_IX_W-1:0] CSR_HIGH_MARK  = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_LOW_MARK   = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_HAVE_PSETS = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      RSP_ACCEPTED  = 3'd0,
      RSP_DROPPED   = 3'd1,
      RSP_FRAME_OUT = 3'd2,
      RSP_SKIPPED   = 3'd3,
      RSP_EMPTY     = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_POP_READ
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic push;
      logic pop_empty;
      logic pop_read;
      logic pop_finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
   } dp_stat_type;

endpackage

[rtl/video_frame_queue_admission.sv]
// ----------------------------------------------------------------------------
// video_frame_queue_admission
// frame descriptor queue with high/low watermarks and keyframe recovery
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request gives
// exactly one result, shown for one cycle with rsp_valid high, and the
// receiver cannot stall it. For a push, and for a pop on an empty queue, the
// result appears in the cycle after the transfer and busy stays low, so such
// requests may come every cycle. A pop of a stored frame first registers the
// descriptor memory read, then the timestamp is scaled by 10000 in one
// multiplier; busy is high while it is scaled and the result appears right
// after it. The user must write registers through the csr_ port only while
// no request is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module video_frame_queue_admission
   import vfqa_pkg::*;
#(
   parameter int QUEUE_DEPTH = VFQA_QUEUE_DEPTH
)
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic                req_mode,
   input  logic [TAG_W-1:0]    req_frame_tag,
   input  logic                req_is_keyframe,
   input  logic [TIME_W-1:0]   req_time_ms,
   // result channel
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_pause_request,
   output logic                rsp_resume_request,
   output logic [TAG_W-1:0]    rsp_out_tag,
   output logic                rsp_out_keyframe,
   output logic [OTIME_W-1:0]  rsp_out_time_100ns,
   output logic                rsp_inject_param_sets,
   output logic [FILL_W-1:0]   rsp_fill_level,
   // register write port
   input  logic                csr_write_en,
   input  logic [CSR_IX_W-1:0] csr_index,
   input  logic [CSR_D_W-1:0]  csr_wdata
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: push and empty pop issue from S_IDLE, a stored pop passes through S_POP_READ
   vfqa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .dp_stat  (dp_stat),
      .dp_cmd   (dp_cmd),
      .busy     (busy)
   );

   // queue storage, flags, watermark checks and result registers
   vfqa_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .dp_cmd                (dp_cmd),
      .dp_stat               (dp_stat),
      .req_frame_tag         (req_frame_tag),
      .req_is_keyframe       (req_is_keyframe),
      .req_time_ms           (req_time_ms),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_pause_request     (rsp_pause_request),
      .rsp_resume_request    (rsp_resume_request),
      .rsp_out_tag           (rsp_out_tag),
      .rsp_out_keyframe      (rsp_out_keyframe),
      .rsp_out_time_100ns    (rsp_out_time_100ns),
      .rsp_inject_param_sets (rsp_inject_param_sets),
      .rsp_fill_level        (rsp_fill_level)
   );

   // a result never shows while a stored pop holds busy
   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && busy))
      else $error("result strobe during busy");

   // every transfer gives a result next cycle or starts the pop read
   a_transfer_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("transfer without result or pop read");

   // after the pop read state busy drops and the result is delivered
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("busy longer than one cycle");

   // watermark requests come only from pushes
   a_marks_on_push: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_pause_request || rsp_resume_request)) |->
      (rsp_status == RSP_ACCEPTED || rsp_status == RSP_DROPPED))
      else $error("watermark request on a pop");

endmodule

[rtl/vfqa_ctrl.sv]
// ----------------------------------------------------------------------------
// vfqa_ctrl
// sequencer: decodes requests into datapath commands, holds off during a pop
// ----------------------------------------------------------------------------
module vfqa_ctrl
   import vfqa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        req_mode,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd,
   output logic        busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      busy     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_mode == MODE_PUSH) begin
                  dp_cmd.push = 1'b1;
               end else if (dp_stat.empty) begin
                  dp_cmd.pop_empty = 1'b1;
               end else begin
                  dp_cmd.pop_read = 1'b1;
                  state_in        = S_POP_READ;
               end
            end
         end
         S_POP_READ: begin
            // head entry is in the read register
            busy              = 1'b1;
            dp_cmd.pop_finish = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/vfqa_dp.sv]
// ----------------------------------------------------------------------------
// vfqa_dp
// datapath: registers, descriptor memory, queue pointers, flags, result regs
// ----------------------------------------------------------------------------
module vfqa_dp
   import vfqa_pkg::*;
#(
   parameter int QUEUE_DEPTH = VFQA_QUEUE_DEPTH
)
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          dp_cmd,
   output dp_stat_type         dp_stat,
   input  logic [TAG_W-1:0]    req_frame_tag,
   input  logic                req_is_keyframe,
   input  logic [TIME_W-1:0]   req_time_ms,
   input  logic                csr_write_en,
   input  logic [CSR_IX_W-1:0] csr_index,
   input  logic [CSR_D_W-1:0]  csr_wdata,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_pause_request,
   output logic                rsp_resume_request,
   output logic [TAG_W-1:0]    rsp_out_tag,
   output logic                rsp_out_keyframe,
   output logic [OTIME_W-1:0]  rsp_out_time_100ns,
   output logic                rsp_inject_param_sets,
   output logic [FILL_W-1:0]   rsp_fill_level
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int MW = (CW > MARK_W) ? CW : MARK_W;
   localparam logic [IW-1:0] LAST_IX = IW'(QUEUE_DEPTH - 1);

   // descriptor memory: {keyframe, tag} and time
   logic [TAG_W:0]    tag_mem [QUEUE_DEPTH];
   logic [TIME_W-1:0] time_mem [QUEUE_DEPTH];
   logic [TAG_W:0]    rd_tag_ff;
   logic [TIME_W-1:0] rd_time_ff;

   // configuration
   logic [MARK_W-1:0] high_mark_ff;
   logic [MARK_W-1:0] low_mark_ff;
   logic              have_psets_ff;

   // queue control
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          paused_ff, paused_in;
   logic          dropped_ff, dropped_in;
   logic          injected_ff, injected_in;

   // result registers
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic                pause_ff, pause_in;
   logic                resume_ff, resume_in;
   logic [TAG_W-1:0]    otag_ff, otag_in;
   logic                okey_ff, okey_in;
   logic [OTIME_W-1:0]  otime_ff, otime_in;
   logic                inject_ff, inject_in;
   logic [FILL_W-1:0]   ofill_ff, ofill_in;

   logic                full;
   logic                store_en;
   logic [CW-1:0]       push_fill;
   logic [MW-1:0]       push_fill_ext;
   logic                pause_hit;
   logic                paused_mid;
   logic                resume_hit;
   logic                rd_key;
   logic [OTIME_W-1:0]  time_scaled;

   assign full     = (fill_ff == CW'(QUEUE_DEPTH));
   assign store_en = dp_cmd.push && !full;
   assign dp_stat.empty = (fill_ff == '0);

   // watermark checks on the fill after the push
   assign push_fill     = full ? fill_ff : fill_ff + CW'(1);
   assign push_fill_ext = MW'(push_fill);
   assign pause_hit     = !paused_ff && (push_fill_ext >= MW'(high_mark_ff));
   assign paused_mid    = paused_ff || pause_hit;
   assign resume_hit    = paused_mid && (push_fill_ext <= MW'(low_mark_ff));

   assign rd_key      = rd_tag_ff[TAG_W];
   assign time_scaled = 54'(rd_time_ff) * 54'(MS_TO_100NS);

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (store_en) begin
         tag_mem[tail_ff]  <= {req_is_keyframe, req_frame_tag};
         time_mem[tail_ff] <= req_time_ms;
      end
      if (dp_cmd.pop_read) begin
         rd_tag_ff  <= tag_mem[head_ff];
         rd_time_ff <= time_mem[head_ff];
      end
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      paused_in    = paused_ff;
      dropped_in   = dropped_ff;
      injected_in  = injected_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      pause_in     = pause_ff;
      resume_in    = resume_ff;
      otag_in      = otag_ff;
      okey_in      = okey_ff;
      otime_in     = otime_ff;
      inject_in    = inject_ff;
      ofill_in     = ofill_ff;

      if (dp_cmd.push) begin
         rsp_valid_in = 1'b1;
         if (full) begin
            dropped_in = 1'b1;
            status_in  = RSP_DROPPED;
         end else begin
            tail_in   = (tail_ff == LAST_IX) ? '0 : tail_ff + IW'(1);
            fill_in   = push_fill;
            status_in = RSP_ACCEPTED;
         end
         paused_in = paused_mid && !resume_hit;
         pause_in  = pause_hit;
         resume_in = resume_hit;
         otag_in   = '0;
         okey_in   = 1'b0;
         otime_in  = '0;
         inject_in = 1'b0;
         ofill_in  = push_fill_ext[FILL_W-1:0];
      end else if (dp_cmd.pop_empty) begin
         rsp_valid_in = 1'b1;
         status_in    = RSP_EMPTY;
         pause_in     = 1'b0;
         resume_in    = 1'b0;
         otag_in      = '0;
         okey_in      = 1'b0;
         otime_in     = '0;
         inject_in    = 1'b0;
         ofill_in     = FILL_W'(fill_ff);
      end else if (dp_cmd.pop_finish) begin
         rsp_valid_in = 1'b1;
         head_in      = (head_ff == LAST_IX) ? '0 : head_ff + IW'(1);
         fill_in      = fill_ff - CW'(1);
         pause_in     = 1'b0;
         resume_in    = 1'b0;
         otag_in      = rd_tag_ff[TAG_W-1:0];
         ofill_in     = FILL_W'(fill_in);
         if (dropped_ff && !rd_key) begin
            // still recovering: skip non-keyframes
            status_in = RSP_SKIPPED;
            okey_in   = 1'b0;
            otime_in  = '0;
            inject_in = 1'b0;
         end else begin
            dropped_in = 1'b0;
            status_in  = RSP_FRAME_OUT;
            okey_in    = rd_key;
            otime_in   = time_scaled;
            inject_in  = rd_key && !injected_ff && have_psets_ff;
            if (inject_in) begin
               injected_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_mark_ff  <= HIGH_MARK_RST;
         low_mark_ff   <= LOW_MARK_RST;
         have_psets_ff <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         paused_ff     <= 1'b0;
         dropped_ff    <= 1'b0;
         injected_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_HIGH_MARK:  high_mark_ff  <= csr_wdata;
               CSR_LOW_MARK:   low_mark_ff   <= csr_wdata;
               CSR_HAVE_PSETS: have_psets_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         paused_ff    <= paused_in;
         dropped_ff   <= dropped_in;
         injected_ff  <= injected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      pause_ff  <= pause_in;
      resume_ff <= resume_in;
      otag_ff   <= otag_in;
      okey_ff   <= okey_in;
      otime_ff  <= otime_in;
      inject_ff <= inject_in;
      ofill_ff  <= ofill_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_pause_request     = pause_ff;
   assign rsp_resume_request    = resume_ff;
   assign rsp_out_tag           = otag_ff;
   assign rsp_out_keyframe      = okey_ff;
   assign rsp_out_time_100ns    = otime_ff;
   assign rsp_inject_param_sets = inject_ff;
   assign rsp_fill_level        = ofill_ff;

endmodule
